@@ rtl/ssbseg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbseg_pkg - shared types and constants of the SRAM bank segmenter
// Operation codes, command bytes, field widths and the divider result bundle.
// ----------------------------------------------------------------------------
package ssbseg_pkg;

    // request kinds
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // serial command bytes (low two bits carried)
    localparam logic [1:0] CMD_READ  = 2'd3;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // element size codes
    localparam logic [1:0] ESZ_WORD = 2'd2;

    // configuration register indexes
    localparam logic CFG_CHIP_SIZE  = 1'b0;
    localparam logic CFG_CHIP_COUNT = 1'b1;

    // widths
    localparam int ADDR_W   = 30;   // byte address / byte length after scaling
    localparam int CSZ_W    = 25;   // chip size in bytes
    localparam int CCNT_W   = 5;    // chip count
    localparam int TOTAL_W  = 29;   // bank size in bytes
    localparam int CADDR_W  = 24;   // in-chip address
    localparam int OFF_W    = 28;   // buffer offset
    localparam int QUOT_W   = 4;    // chip index
    localparam int STEP_W   = 2;    // divider step counter

    // divider result
    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
        logic [CADDR_W-1:0]  rem;
    } div_res_t;

endpackage

@@ rtl/ssbseg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbseg_div - iterative restoring divider for the chip index
// One trial subtract per cycle over four quotient bits. The dividend must be
// below sixteen times the divisor; the remainder then fits the chip address.
// ----------------------------------------------------------------------------
module ssbseg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ssbseg_pkg::ADDR_W-1:0]       dividend,
    input  logic [ssbseg_pkg::CSZ_W-1:0]        divisor,
    output ssbseg_pkg::div_res_t                res
);
    import ssbseg_pkg::*;

    logic [ADDR_W-1:0] rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ADDR_W-1:0] dvs_sh;
    logic [ADDR_W:0]   trial;

    // shared trial subtract: remainder minus divisor shifted to this step
    always_comb
    begin
        dvs_sh = {{(ADDR_W-CSZ_W){1'b0}}, divisor} << step_reg;
        trial  = {1'b0, rem_reg} - {1'b0, dvs_sh};
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= dividend;
                quot_reg <= '0;
                step_reg <= STEP_W'(QUOT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!trial[ADDR_W])
                begin
                    rem_reg            <= trial[ADDR_W-1:0];
                    quot_reg[step_reg] <= 1'b1;
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg[CADDR_W-1:0];

endmodule

@@ rtl/spi_sram_bank_segmenter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_sram_bank_segmenter_top - maps an access request onto serial SRAM chips
// Splits a read, write or fill request into one word per chip-bounded segment.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (op in s_tuser). Each accepted word gives
//   one segment word per chip touched on the m_ channel, m_tlast on the final
//   one, or a single error word (m_tuser high) when the range passes the end
//   of the bank. Zero-length read and write requests and op code 3 give nothing.
//   chip_size and chip_count are written over the cfg_ channel while idle;
//   cfg_ready is always high.
// Timing:
//   accept, bank-size multiply, range check, then the shared restoring
//   divider that finds the first chip; after that the segments in order,
//   each waiting while the receiver stalls. s_tready returns once the last
//   segment or the error word is loaded. The divider sets the setup cost.
// Reset and stall:
//   reset returns chip_size to 131072, chip_count to 1 and drops all words in
//   flight. A stalled receiver holds the output register; the sequencer waits
//   with the next segment and s_tready stays low until the request is done.
// ----------------------------------------------------------------------------
module spi_sram_bank_segmenter_top #(
    parameter int MAX_CHIPS         = 16,
    parameter int CHIP_ADDRESS_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: start_address[27:0], length[55:28], element_size[57:56], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // segment: chip_index[3:0], chip_address[27:4], command[29:28],
    // byte_count[54:30], buffer_offset[82:55], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    // error[0]
    output logic        m_tuser,
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);
    import ssbseg_pkg::*;

    localparam logic [CSZ_W-1:0]  CSZ_MAX  = CSZ_W'(1) << CHIP_ADDRESS_BITS;
    localparam logic [CCNT_W-1:0] CCNT_MAX = CCNT_W'(MAX_CHIPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_SEG
    } state_t;

    state_t             state_reg;
    logic [CSZ_W-1:0]   chip_size_reg;
    logic [CCNT_W-1:0]  chip_count_reg;

    logic [CSZ_W-1:0]   csz_reg;
    logic [CCNT_W-1:0]  ccnt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               fill_reg;
    logic [1:0]         cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  len_reg;
    logic [QUOT_W-1:0]  chip_reg;
    logic [CADDR_W-1:0] caddr_reg;
    logic [CSZ_W-1:0]   left_reg;
    logic [OFF_W-1:0]   off_reg;

    logic               m_valid_reg;
    logic [QUOT_W-1:0]  o_chip_reg;
    logic [CADDR_W-1:0] o_caddr_reg;
    logic [1:0]         o_cmd_reg;
    logic [CSZ_W-1:0]   o_cnt_reg;
    logic [OFF_W-1:0]   o_off_reg;
    logic               o_last_reg;
    logic               o_err_reg;

    div_res_t           div_res;
    logic               div_start;

    logic               in_acc;
    logic [1:0]         in_op;
    logic [27:0]        in_addr;
    logic [27:0]        in_len;
    logic [1:0]         in_esz;
    logic [CSZ_W-1:0]   csz_eff;
    logic [CCNT_W-1:0]  ccnt_eff;
    logic [29:0]        product;
    logic [ADDR_W:0]    range_end;
    logic               range_err;
    logic               slot_free;
    logic               out_load;
    logic [CSZ_W-1:0]   seg_cnt;
    logic [ADDR_W-1:0]  len_next;
    logic [OFF_W-1:0]   off_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_size_reg  <= CSZ_W'(131072);
            chip_count_reg <= CCNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHIP_SIZE:  chip_size_reg  <= cfg_data;
                CFG_CHIP_COUNT: chip_count_reg <= cfg_data[CCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // request decode and clamping of the configuration
    always_comb
    begin
        in_op   = s_tuser;
        in_addr = s_tdata[27:0];
        in_len  = s_tdata[55:28];
        in_esz  = (s_tdata[57:56] > ESZ_WORD) ? ESZ_WORD : s_tdata[57:56];
        if (chip_size_reg == '0)
            csz_eff = CSZ_W'(1);
        else if (chip_size_reg > CSZ_MAX)
            csz_eff = CSZ_MAX;
        else
            csz_eff = chip_size_reg;
        if (chip_count_reg == '0)
            ccnt_eff = CCNT_W'(1);
        else if (chip_count_reg > CCNT_MAX)
            ccnt_eff = CCNT_MAX;
        else
            ccnt_eff = chip_count_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // bank size, range check and segment length
    always_comb
    begin
        product   = {5'b0, csz_reg} * {25'b0, ccnt_reg};
        range_end = {1'b0, addr_reg} + {1'b0, len_reg};
        range_err = range_end > {2'b0, total_reg};
        slot_free = !m_valid_reg || m_tready;
        seg_cnt   = ({5'b0, left_reg} < len_reg) ? left_reg : len_reg[CSZ_W-1:0];
        len_next  = len_reg - {5'b0, seg_cnt};
        off_next  = off_reg + {3'b0, seg_cnt};
    end

    // a new word enters the output register
    assign out_load = slot_free &&
                      ((state_reg == ST_CHECK && range_err) || state_reg == ST_SEG);

    assign div_start = (state_reg == ST_CHECK) && !range_err;

    ssbseg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg),
        .divisor  (csz_reg),
        .res      (div_res)
    );

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            csz_reg     <= '0;
            ccnt_reg    <= '0;
            total_reg   <= '0;
            fill_reg    <= 1'b0;
            cmd_reg     <= '0;
            addr_reg    <= '0;
            len_reg     <= '0;
            chip_reg    <= '0;
            caddr_reg   <= '0;
            left_reg    <= '0;
            off_reg     <= '0;
            m_valid_reg <= 1'b0;
            o_chip_reg  <= '0;
            o_caddr_reg <= '0;
            o_cmd_reg   <= '0;
            o_cnt_reg   <= '0;
            o_off_reg   <= '0;
            o_last_reg  <= 1'b0;
            o_err_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_op != OP_NONE &&
                        (in_op == OP_FILL || in_len != '0))
                    begin
                        csz_reg  <= csz_eff;
                        ccnt_reg <= ccnt_eff;
                        fill_reg <= (in_op == OP_FILL);
                        cmd_reg  <= (in_op == OP_READ) ? CMD_READ : CMD_WRITE;
                        if (in_op == OP_FILL)
                            addr_reg <= '0;
                        else
                            addr_reg <= {2'b0, in_addr} << in_esz;
                        len_reg   <= {2'b0, in_len} << in_esz;
                        state_reg <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    total_reg <= product[TOTAL_W-1:0];
                    if (fill_reg)
                        len_reg <= {1'b0, product[TOTAL_W-1:0]};
                    state_reg <= ST_CHECK;
                end

                ST_CHECK:
                begin
                    if (!range_err)
                        state_reg <= ST_DIV;
                    else if (slot_free)
                    begin
                        // out of bank: one error word
                        o_chip_reg  <= '0;
                        o_caddr_reg <= '0;
                        o_cmd_reg   <= cmd_reg;
                        o_cnt_reg   <= '0;
                        o_off_reg   <= '0;
                        o_last_reg  <= 1'b1;
                        o_err_reg   <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        chip_reg  <= div_res.quot;
                        caddr_reg <= div_res.rem;
                        left_reg  <= csz_reg - {1'b0, div_res.rem};
                        off_reg   <= '0;
                        state_reg <= ST_SEG;
                    end
                end

                ST_SEG:
                begin
                    if (slot_free)
                    begin
                        o_chip_reg  <= chip_reg;
                        o_caddr_reg <= caddr_reg;
                        o_cmd_reg   <= cmd_reg;
                        o_cnt_reg   <= seg_cnt;
                        o_off_reg   <= off_reg;
                        o_last_reg  <= (len_next == '0);
                        o_err_reg   <= 1'b0;
                        // later segments start at the bottom of their chip
                        caddr_reg   <= '0;
                        len_reg     <= len_next;
                        off_reg     <= off_next;
                        chip_reg    <= chip_reg + 1'b1;
                        left_reg    <= csz_reg;
                        if (len_next == '0)
                            state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_off_reg, o_cnt_reg, o_cmd_reg, o_caddr_reg, o_chip_reg};
    assign m_tuser  = o_err_reg;
    assign m_tlast  = o_last_reg;

endmodule

@@ rtl/ssbseg_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssbseg_chk - port checker for the SRAM bank segmenter
// Watches the output channel for well-formed segment and error words.
// ----------------------------------------------------------------------------
module ssbseg_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import ssbseg_pkg::*;

    // an error word closes its request and carries no segment
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[54:30] == '0 && m_tdata[3:0] == '0)
        else $error("error word without last or with segment data");

    // a real segment always moves at least one byte
    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[54:30] != '0)
        else $error("empty segment");

    // only read and write commands are issued
    a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[29:28] == CMD_READ || m_tdata[29:28] == CMD_WRITE)
        else $error("illegal command byte");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

endmodule

bind spi_sram_bank_segmenter_top ssbseg_chk u_ssbseg_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/seg_map_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seg_map_checker - segment prediction and comparison for the bank segmenter
// Watches the request, segment and configuration channels. Keeps its own copy
// of chip_size and chip_count, works out the segment words that each accepted
// request must give, and compares every accepted segment word field by field.
// ----------------------------------------------------------------------------
module seg_map_checker #(
    parameter int MAX_CHIPS         = 16,
    parameter int CHIP_ADDRESS_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          segments_seen,
    output int          range_errors_seen
);
    import ssbseg_pkg::*;

    // one segment word as the block should send it
    typedef struct packed {
        logic [3:0]  chip;
        logic [23:0] chip_addr;
        logic [1:0]  cmd;
        logic [24:0] count;
        logic [27:0] offset;
        logic        last;
        logic        err;
    } segment_t;

    segment_t         segments_due[$];
    logic [24:0]      chip_size_q;
    logic [4:0]       chip_count_q;

    // print one line per mismatch and count them all
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // turn one request into the segment words it causes
    function automatic void map_to_segments(input logic [1:0] op,
                                            input logic [27:0] start,
                                            input logic [27:0] elems,
                                            input logic [1:0] esz_code);
        longint unsigned size_b;
        longint unsigned chips;
        longint unsigned bank;
        longint unsigned addr;
        longint unsigned len;
        longint unsigned chip;
        longint unsigned inner;
        longint unsigned room;
        longint unsigned n;
        longint unsigned off;
        logic [1:0]      esz;
        logic [1:0]      cmd;
        int              k;
        segment_t        seg;

        if (op == OP_NONE)
            return;
        esz = (esz_code > ESZ_WORD) ? ESZ_WORD : esz_code;

        // out-of-range register values are clamped
        size_b = chip_size_q;
        if (size_b == 0)
            size_b = 1;
        if (size_b > (64'd1 << CHIP_ADDRESS_BITS))
            size_b = 64'd1 << CHIP_ADDRESS_BITS;
        chips = chip_count_q;
        if (chips == 0)
            chips = 1;
        if (chips > MAX_CHIPS)
            chips = MAX_CHIPS;
        bank = size_b * chips;

        if (op == OP_FILL)
        begin
            addr = 0;
            len  = bank;
            cmd  = CMD_WRITE;
        end
        else
        begin
            addr = start;
            len  = elems;
            addr = addr << esz;
            len  = len << esz;
            cmd  = (op == OP_READ) ? CMD_READ : CMD_WRITE;
        end

        if (len == 0)
            return;

        // range past the bank: a single error word
        if (addr + len > bank)
        begin
            seg        = '0;
            seg.cmd    = cmd;
            seg.last   = 1'b1;
            seg.err    = 1'b1;
            segments_due.push_back(seg);
            return;
        end

        off = 0;
        k   = 0;
        while (len > 0 && k < MAX_CHIPS)
        begin
            chip   = addr / size_b;
            inner  = addr - chip * size_b;
            room   = size_b - inner;
            n      = (room < len) ? room : len;
            len    = len - n;
            seg.chip      = 4'(chip);
            seg.chip_addr = 24'(inner);
            seg.cmd       = cmd;
            seg.count     = 25'(n);
            seg.offset    = 28'(off);
            seg.last      = (len == 0);
            seg.err       = 1'b0;
            segments_due.push_back(seg);
            k++;
            addr = addr + n;
            off  = off + n;
        end
    endfunction

    // channel monitor: results first, then configuration, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            segments_due.delete();
            chip_size_q  = 25'd131072;
            chip_count_q = 5'd1;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                segments_seen++;
                if (m_tuser)
                    range_errors_seen++;
                if (segments_due.size() == 0)
                    report_mismatch("segment word with none expected",
                                    64'(m_tdata), 64'd0);
                else
                begin
                    want = segments_due.pop_front();
                    if (m_tdata[3:0] != want.chip)
                        report_mismatch("chip_index", 64'(m_tdata[3:0]), 64'(want.chip));
                    if (m_tdata[27:4] != want.chip_addr)
                        report_mismatch("chip_address", 64'(m_tdata[27:4]),
                                        64'(want.chip_addr));
                    if (m_tdata[29:28] != want.cmd)
                        report_mismatch("command", 64'(m_tdata[29:28]), 64'(want.cmd));
                    if (m_tdata[54:30] != want.count)
                        report_mismatch("byte_count", 64'(m_tdata[54:30]), 64'(want.count));
                    if (m_tdata[82:55] != want.offset)
                        report_mismatch("buffer_offset", 64'(m_tdata[82:55]),
                                        64'(want.offset));
                    if (m_tlast !== want.last)
                        report_mismatch("last", 64'(m_tlast), 64'(want.last));
                    if (m_tuser !== want.err)
                        report_mismatch("error", 64'(m_tuser), 64'(want.err));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CHIP_SIZE)
                    chip_size_q = cfg_data;
                else
                    chip_count_q = cfg_data[4:0];
            end

            if (s_tvalid && s_tready)
                map_to_segments(s_tuser, s_tdata[27:0], s_tdata[55:28], s_tdata[57:56]);

            pending <= segments_due.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top level for the SRAM bank segmenter
// Writes a series of bank settings, sends a directed set of requests and then
// random ones shaped to the bank in use, under four flow-control modes, and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
    import ssbseg_pkg::*;

    localparam int MAX_CHIPS         = 16;
    localparam int CHIP_ADDRESS_BITS = 24;
    localparam int QUIET_LIMIT       = 2000;   // cycles with no word moving
    localparam int SETTLE_CYCLES     = 40;     // covers the divider and sequencer
    localparam int PHASE_ITEMS       = 29;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_READ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_CHIP_SIZE;
    logic [24:0] cfg_data = '0;

    int mismatches;
    int pending;
    int segments_seen;
    int range_errors_seen;

    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              requests_sent = 0;
    int              settings_used = 0;
    int              quiet_cycles = 0;
    longint unsigned chip_bytes;
    longint unsigned bank_bytes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spi_sram_bank_segmenter_top #(
        .MAX_CHIPS         (MAX_CHIPS),
        .CHIP_ADDRESS_BITS (CHIP_ADDRESS_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    seg_map_checker #(
        .MAX_CHIPS         (MAX_CHIPS),
        .CHIP_ADDRESS_BITS (CHIP_ADDRESS_BITS)
    ) checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .pending           (pending),
        .segments_seen     (segments_seen),
        .range_errors_seen (range_errors_seen)
    );

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // watchdog: ends the run when no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one request word, with random gaps ahead of it
    task automatic send_request(input logic [1:0] op, input logic [27:0] addr,
                                input logic [27:0] len, input logic [1:0] esz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, esz, len, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // let the checker update first so that the count includes the word just accepted
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [24:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // let the block go idle, then write both registers
    task automatic set_bank(input logic [24:0] size, input logic [4:0] count);
        longint unsigned chips;
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_CHIP_SIZE, size);
        write_reg(CFG_CHIP_COUNT, {20'b0, count});
        cfg_valid <= 1'b0;
        chip_bytes = (size == 0) ? 1 : size;
        if (chip_bytes > (64'd1 << CHIP_ADDRESS_BITS))
            chip_bytes = 64'd1 << CHIP_ADDRESS_BITS;
        chips = (count == 0) ? 1 : count;
        if (chips > MAX_CHIPS)
            chips = MAX_CHIPS;
        bank_bytes = chip_bytes * chips;
        settings_used++;
    endtask

    // one random request; mostly ranges inside the bank, the rest edge and noise
    task automatic random_request(output logic counted);
        int              pick;
        logic [1:0]      op;
        logic [1:0]      esz;
        logic [1:0]      ez;
        longint unsigned units;
        longint unsigned start;
        longint unsigned room;
        longint unsigned span;
        longint unsigned len;

        pick    = $urandom_range(99);
        op      = $urandom_range(1) ? OP_WRITE : OP_READ;
        esz     = 2'($urandom_range(3));
        counted = 1'b1;
        if (pick < 8)
            send_request(OP_FILL, 28'($urandom), 28'($urandom), esz);
        else if (pick < 14)
        begin
            // unused op code: no result expected
            send_request(OP_NONE, 28'($urandom), 28'($urandom), esz);
            counted = 1'b0;
        end
        else if (pick < 20)
            send_request(op, 28'($urandom), 28'd0, esz);
        else if (pick < 30)
            send_request(op, 28'($urandom), 28'($urandom), esz);
        else
        begin
            ez    = (esz > ESZ_WORD) ? ESZ_WORD : esz;
            units = bank_bytes >> ez;
            if (units == 0)
                send_request(op, 28'd0, 28'd1, esz);
            else
            begin
                start = $urandom % units;
                room  = units - start;
                pick  = $urandom_range(9);
                if (pick < 2)
                    len = room;
                else if (pick < 6)
                begin
                    span = ((chip_bytes >> ez) * 2) + 1;
                    span = (span < room) ? span : room;
                    len  = 1 + ($urandom % span);
                end
                else
                    len = 1 + ($urandom % room);
                send_request(op, 28'(start), 28'(len), esz);
            end
        end
    endtask

    // one bank setting under one flow-control mode, with a drain mid-way
    task automatic run_phase(input logic [24:0] size, input logic [4:0] count,
                             input int idle_pct, input int stall_pct);
        int   done_items;
        logic counted;
        set_bank(size, count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done_items     = 0;
        while (done_items < PHASE_ITEMS)
        begin
            if (done_items == PHASE_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            random_request(counted);
            if (counted)
                done_items++;
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 4 chips of 4 KiB, no idling
        set_bank(25'd4096, 5'd4);
        send_request(OP_READ,  28'd0,         28'd1,         2'd0);
        send_request(OP_WRITE, 28'd4095,      28'd2,         2'd0);  // crosses a chip edge
        send_request(OP_READ,  28'd2048,      28'd2048,      2'd1);  // exactly chip 1
        send_request(OP_WRITE, 28'd0,         28'd4096,      2'd2);  // whole bank in words
        send_request(OP_READ,  28'd1,         28'd3,         2'd3);  // size code 3 acts as word
        send_request(OP_FILL,  28'hFFFFFFF,   28'hFFFFFFF,   2'd0);
        send_request(OP_READ,  28'hFFFFFFF,   28'd0,         2'd2);  // zero length past bank
        send_request(OP_WRITE, 28'd0,         28'd0,         2'd0);
        send_request(OP_READ,  28'd16383,     28'd2,         2'd0);  // one byte too far
        send_request(OP_WRITE, 28'hFFFFFFF,   28'hFFFFFFF,   2'd2);
        send_request(OP_NONE,  28'hFFFFFFF,   28'hFFFFFFF,   2'd3);  // ignored op
        send_request(OP_READ,  28'd16383,     28'd1,         2'd0);  // last byte of bank
        send_request(OP_WRITE, 28'd8191,      28'd1,         2'd1);
        send_request(OP_READ,  28'd4095,      28'd2,         2'd2);  // word range overruns
        send_request(OP_READ,  28'd0,         28'd16384,     2'd0);
        send_request(OP_FILL,  28'd0,         28'd0,         2'd3);

        // directed: the largest bank, sixteen full chips
        set_bank(25'd16777216, 5'd16);
        send_request(OP_FILL,  28'd0,         28'd0,         2'd0);
        send_request(OP_READ,  28'd0,         28'h4000000,   2'd2);
        send_request(OP_WRITE, 28'hFFFFFFF,   28'd1,         2'd0);
        s_tvalid <= 1'b0;

        // random phases: none, sender idle, receiver stall, both
        run_phase(25'd1000,       5'd3,  0,  0);
        run_phase(25'd16777216,   5'd16, 83, 0);
        run_phase(25'd1,          5'd16, 0,  83);
        run_phase(25'd0,          5'd0,  21, 21);
        run_phase(25'h1FFFFFF,    5'd31, 0,  0);
        run_phase(25'd777,        5'd17, 0,  83);
        run_phase(25'd65536,      5'd5,  83, 0);
        run_phase(25'd8388609,    5'd2,  21, 21);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests over %0d bank settings and four flow-control modes.",
                 requests_sent, settings_used);
        $display("%0d segment words checked, %0d of them range errors; %0d mismatches.",
                 segments_seen, range_errors_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
